>>> design/csrcn_pkg.sv
// Shared types and constants of the CSR common-neighbour counter.
// Field widths, operation codes and the command and status bundles between
// controller and datapath. No dependencies.
package csrcn_pkg;

  localparam int OP_W     = 2;
  localparam int INDEX_W  = 14;
  localparam int VALUE_W  = 15;
  localparam int VERTEX_W = 10;
  localparam int PART_W   = 3;
  localparam int COUNT_W  = 11;
  localparam int VCOUNT_W = 11;
  localparam int NEIGH_W  = 10;

  localparam int DEF_MAX_VERTICES   = 1024;
  localparam int DEF_MAX_PARTITIONS = 8;
  localparam int DEF_MAX_EDGES      = 16384;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(1024);
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

  localparam logic [OP_W-1:0] OP_WR_OFFSET = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_EDGE   = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT     = 2'd2;

  typedef enum logic [1:0] {
    OFF_U,
    OFF_U_END,
    OFF_V,
    OFF_V_END
  } off_sel_e;

  typedef struct packed {
    logic     accept;
    logic     load;
    logic     base;
    off_sel_e off_sel;
    logic     cap_us;
    logic     cap_ue;
    logic     cap_vs;
    logic     cap_ve;
    logic     merge_init;
    logic     merge_step;
    logic     res_load;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic bad;
    logic active;
  } sts_t;

endpackage

>>> design/csrcn_req_if.sv
// Request channel of the CSR common-neighbour counter: valid, ready and one
// item of write or query fields. Depends on csrcn_pkg.
interface csrcn_req_if import csrcn_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [INDEX_W-1:0]  index;
  logic [VALUE_W-1:0]  value;
  logic [VERTEX_W-1:0] vertex_u;
  logic [VERTEX_W-1:0] vertex_v;
  logic [PART_W-1:0]   partition;

  modport source (
    output valid, operation, index, value, vertex_u, vertex_v, partition,
    input  ready
  );
  modport sink (
    input  valid, operation, index, value, vertex_u, vertex_v, partition,
    output ready
  );
endinterface

>>> design/csrcn_rsp_if.sv
// Response channel of the CSR common-neighbour counter: valid, ready,
// the count result and the bad-request flag. Depends on csrcn_pkg.
interface csrcn_rsp_if import csrcn_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] common_count;
  logic               bad_request;

  modport source (
    output valid, common_count, bad_request,
    input  ready
  );
  modport sink (
    input  valid, common_count, bad_request,
    output ready
  );
endinterface

>>> design/csrcn_ctrl.sv
// Controller of the CSR common-neighbour counter: sequences offset reads,
// the merge walk and the result beat. Depends on csrcn_pkg.
module csrcn_ctrl import csrcn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_RD4,
    S_MERGE,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign accept      = req_valid_i && req_ready_o;
  assign slot_free   = !out_valid_q || rsp_ready_i;

  always_comb begin
    cmd_o         = '0;
    cmd_o.off_sel = OFF_U;
    cmd_o.accept  = accept;
    state_d       = state_q;
    out_valid_d   = out_valid_q && !rsp_ready_i;
    case (state_q)
      S_IDLE: begin
        if (accept && sts_i.is_query) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.base = 1'b1;
        state_d    = sts_i.bad ? S_DONE : S_RD0;
      end
      S_RD0: begin
        cmd_o.off_sel = OFF_U;
        state_d       = S_RD1;
      end
      S_RD1: begin
        cmd_o.off_sel = OFF_U_END;
        cmd_o.cap_us  = 1'b1;
        state_d       = S_RD2;
      end
      S_RD2: begin
        cmd_o.off_sel = OFF_V;
        cmd_o.cap_ue  = 1'b1;
        state_d       = S_RD3;
      end
      S_RD3: begin
        cmd_o.off_sel = OFF_V_END;
        cmd_o.cap_vs  = 1'b1;
        state_d       = S_RD4;
      end
      S_RD4: begin
        cmd_o.cap_ve     = 1'b1;
        cmd_o.merge_init = 1'b1;
        state_d          = S_MERGE;
      end
      S_MERGE: begin
        cmd_o.merge_step = 1'b1;
        if (!sts_i.active) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> design/csrcn_dp.sv
// Datapath of the CSR common-neighbour counter: offset and edge memories,
// the vertex count register, range pointers and the merge compare.
// Depends on csrcn_pkg; driven by csrcn_ctrl commands.
module csrcn_dp import csrcn_pkg::*; #(
  parameter int MAX_VERTICES   = DEF_MAX_VERTICES,
  parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS,
  parameter int MAX_EDGES      = DEF_MAX_EDGES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [VCOUNT_W-1:0] cfg_wdata_i,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [INDEX_W-1:0]  index_i,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic [VERTEX_W-1:0] vertex_u_i,
  input  logic [VERTEX_W-1:0] vertex_v_i,
  input  logic [PART_W-1:0]   partition_i,
  output logic [COUNT_W-1:0]  common_count_o,
  output logic                bad_request_o,
  input  cmd_t                cmd_i,
  output sts_t                sts_o
);

  localparam int OFF_DEPTH = MAX_PARTITIONS * MAX_VERTICES + 1;
  localparam int OFF_AW    = $clog2(OFF_DEPTH);
  localparam int EDGE_AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int PTR_W     = $clog2(MAX_EDGES + 1);
  localparam int NV_W      = $clog2(MAX_VERTICES + 1);

  logic [VALUE_W-1:0] off_mem [OFF_DEPTH];
  logic [NEIGH_W-1:0] edge_mem [MAX_EDGES];

  logic [VCOUNT_W-1:0] vcount_q;
  logic [VERTEX_W-1:0] u_q, v_q;
  logic [PART_W-1:0]   part_q;
  logic [NV_W-1:0]     n_q;
  logic [NV_W-1:0]     n_d;
  logic [OFF_AW-1:0]   base_q;
  logic [OFF_AW-1:0]   off_addr;
  logic [VALUE_W-1:0]  off_rd_q;
  logic [PTR_W-1:0]    bound;
  logic [PTR_W-1:0]    us_q, ue_q, vs_q, ve_q;
  logic [PTR_W-1:0]    a_q, b_q, a_nx, b_nx;
  logic [PTR_W-1:0]    a_rd, b_rd;
  logic [NEIGH_W-1:0]  x_q, y_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic [COUNT_W-1:0]  res_count_q;
  logic                res_bad_q;
  logic                bad;
  logic                active;
  logic                a_inc, b_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RESET;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (vcount_q == '0) begin
      n_d = NV_W'(1);
    end else if (32'(vcount_q) > 32'(MAX_VERTICES)) begin
      n_d = NV_W'(MAX_VERTICES);
    end else begin
      n_d = NV_W'(vcount_q);
    end
  end

  assign bad = (32'(u_q) >= 32'(n_q)) || (32'(v_q) >= 32'(n_q)) ||
               (32'(part_q) >= 32'(MAX_PARTITIONS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      u_q    <= vertex_u_i;
      v_q    <= vertex_v_i;
      part_q <= partition_i;
      n_q    <= n_d;
    end
    if (cmd_i.base) begin
      base_q <= OFF_AW'(part_q) * OFF_AW'(n_q);
    end
  end

  always_comb begin
    case (cmd_i.off_sel)
      OFF_U:     off_addr = base_q + OFF_AW'(u_q);
      OFF_U_END: off_addr = base_q + OFF_AW'(u_q) + OFF_AW'(1);
      OFF_V:     off_addr = base_q + OFF_AW'(v_q);
      OFF_V_END: off_addr = base_q + OFF_AW'(v_q) + OFF_AW'(1);
      default:   off_addr = base_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (operation_i == OP_WR_OFFSET) &&
        (32'(index_i) < 32'(OFF_DEPTH))) begin
      off_mem[OFF_AW'(index_i)] <= value_i;
    end
    off_rd_q <= off_mem[off_addr];
  end

  assign bound = PTR_W'((32'(off_rd_q) > 32'(MAX_EDGES)) ? 32'(MAX_EDGES) : 32'(off_rd_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_us) us_q <= bound;
    if (cmd_i.cap_ue) ue_q <= bound;
    if (cmd_i.cap_vs) vs_q <= bound;
    if (cmd_i.cap_ve) ve_q <= bound;
  end

  assign active = (a_q < ue_q) && (b_q < ve_q);
  assign a_inc  = (x_q <= y_q);
  assign b_inc  = (x_q >= y_q);
  assign a_nx   = a_q + PTR_W'(a_inc);
  assign b_nx   = b_q + PTR_W'(b_inc);
  assign a_rd   = cmd_i.merge_init ? us_q : a_nx;
  assign b_rd   = cmd_i.merge_init ? vs_q : b_nx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (operation_i == OP_WR_EDGE) &&
        (32'(index_i) < 32'(MAX_EDGES))) begin
      edge_mem[EDGE_AW'(index_i)] <= value_i[NEIGH_W-1:0];
    end
    x_q <= edge_mem[a_rd[EDGE_AW-1:0]];
    y_q <= edge_mem[b_rd[EDGE_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.merge_init) begin
      a_q   <= us_q;
      b_q   <= vs_q;
      cnt_q <= '0;
    end else if (cmd_i.merge_step && active) begin
      a_q <= a_nx;
      b_q <= b_nx;
      if ((x_q == y_q) && (cnt_q != COUNT_MAX)) begin
        cnt_q <= cnt_q + COUNT_W'(1);
      end
    end
    if (cmd_i.res_load) begin
      res_count_q <= bad ? '0 : cnt_q;
      res_bad_q   <= bad;
    end
  end

  assign common_count_o = res_count_q;
  assign bad_request_o  = res_bad_q;

  assign sts_o.is_query = (operation_i == OP_COUNT);
  assign sts_o.bad      = bad;
  assign sts_o.active   = active;

endmodule

>>> design/csr_common_neighbour_count.sv
// CSR common-neighbour counter. Write beats load row offsets (operation 0)
// or edge entries (operation 1); a count beat (operation 2) runs a range
// check, four offset reads on the single offset memory port and then the
// merge steps, at most the sum of both adjacency list lengths. Bad queries
// skip the offset reads and the merge. One query is in flight at a time;
// a finished result waits in the output register while new write beats
// are taken. Depends on csrcn_pkg, csrcn_req_if, csrcn_rsp_if, csrcn_ctrl
// and csrcn_dp.
module csr_common_neighbour_count import csrcn_pkg::*; #(
  parameter int MAX_VERTICES   = DEF_MAX_VERTICES,
  parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS,
  parameter int MAX_EDGES      = DEF_MAX_EDGES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [VCOUNT_W-1:0] cfg_wdata_i,
  csrcn_req_if.sink           req_i,
  csrcn_rsp_if.source         rsp_o
);

  cmd_t cmd;
  sts_t sts;

  csrcn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  csrcn_dp #(
    .MAX_VERTICES   (MAX_VERTICES),
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .MAX_EDGES      (MAX_EDGES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (req_i.operation),
    .index_i        (req_i.index),
    .value_i        (req_i.value),
    .vertex_u_i     (req_i.vertex_u),
    .vertex_v_i     (req_i.vertex_v),
    .partition_i    (req_i.partition),
    .common_count_o (rsp_o.common_count),
    .bad_request_o  (rsp_o.bad_request),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule
